@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands. Each use expects signal clk in scope, ASSERT_CHK also rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge except while reset is high.
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/ccm_pkg.sv @@
// ----------------------------------------------------------------------------
// ccm_pkg
// Types, constants and calendar helpers for the calendar clock cron matcher.
// ----------------------------------------------------------------------------
package ccm_pkg;

  localparam int RULE_COUNT_DEF = 32;
  localparam int IN_DATA_W      = 176;
  localparam int OUT_DATA_W     = 40;

  localparam logic [11:0] YEAR_MIN = 12'd1970;
  localparam logic [11:0] YEAR_MAX = 12'd2099;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_LOAD = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WDAY,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [6:0]  weekday_mask;
    logic [11:0] month_mask;
    logic [30:0] day_mask;
    logic [23:0] hour_mask;
    logic [59:0] minute_mask;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [4:0]  rule_index;
  } in_t;

  typedef struct packed {
    logic [6:0]  weekday_mask;
    logic [11:0] month_mask;
    logic [30:0] day_mask;
    logic [23:0] hour_mask;
    logic [59:0] minute_mask;
  } rule_t;

  typedef struct packed {
    logic [2:0]  match_weekday;
    logic [5:0]  match_minute;
    logic [4:0]  match_hour;
    logic [4:0]  match_day;
    logic [3:0]  match_month;
    logic [11:0] match_year;
    logic [4:0]  matched_rule;
  } out_t;

  // Years 1970..2099 only, so divisible by four is enough.
  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'b00);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd2:    n = leap ? 5'd29 : 5'd28;
      4'd4:    n = 5'd30;
      4'd6:    n = 5'd30;
      4'd9:    n = 5'd30;
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

  // Days before month m in a common year, mod 7.
  function automatic logic [2:0] month_ofs7(input logic [3:0] m);
    logic [2:0] r;
    case (m)
      4'd2:    r = 3'd3;
      4'd3:    r = 3'd3;
      4'd4:    r = 3'd6;
      4'd5:    r = 3'd1;
      4'd6:    r = 3'd4;
      4'd7:    r = 3'd6;
      4'd8:    r = 3'd2;
      4'd9:    r = 3'd5;
      4'd10:   r = 3'd0;
      4'd11:   r = 3'd3;
      4'd12:   r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // 8 = 1 mod 7: fold octal digits, then one correction.
  function automatic logic [2:0] mod7(input logic [7:0] x);
    logic [5:0] a;
    logic [3:0] b;
    a = {1'b0, x[7:3]} + {3'b0, x[2:0]};
    b = {1'b0, a[5:3]} + {1'b0, a[2:0]};
    return (b >= 4'd7) ? 3'(b - 4'd7) : b[2:0];
  endfunction

endpackage

@@ rtl/core/calendar_clock_cron_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// calendar_clock_cron_matcher_unit
// Minute calendar clock with a table of cron-style alarm rules.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields
// s        in   tuser: operation; tdata: request (rule_index .. weekday_mask)
// m        out  tdata: matched_rule .. match_weekday; tlast: last_match
//
// Set time: clamp, then weekday. Load rule: one rule memory write.
// Tick: scan of all rules, one rule memory read per cycle, held while a second
// match waits on a stalled output, then a flush that advances the minute.
// Synchronous reset clears time to 1970-01-01 00:00 Thursday and all rules.
// s_tready is high only while idle.
// ----------------------------------------------------------------------------
module calendar_clock_cron_matcher_unit
  import ccm_pkg::*;
#(
  parameter int RULE_COUNT = RULE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // rule_index, year, month, day, hour, minute, minute_mask, hour_mask,
  // day_mask, month_mask, weekday_mask, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // operation
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // matched_rule, match_year, match_month, match_day, match_hour,
  // match_minute, match_weekday
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  localparam int IDX_W = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RULE_COUNT - 1);
  localparam logic [6:0] RULE_LIM = 7'(RULE_COUNT);

  in_t  req;
  op_t  op;
  assign req = in_t'(s_tdata);
  assign op  = op_t'(s_tuser);

  state_t state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             pend_valid, pend_valid_next;
  logic [IDX_W-1:0] pend_rule, pend_rule_next;
  logic             out_valid, out_valid_next;
  out_t             out_data, out_data_next;
  logic             out_last, out_last_next;

  logic [11:0] cur_year, cur_year_next;
  logic [3:0]  cur_month, cur_month_next;
  logic [4:0]  cur_day, cur_day_next;
  logic [4:0]  cur_hour, cur_hour_next;
  logic [5:0]  cur_minute, cur_minute_next;
  logic [2:0]  cur_weekday, cur_weekday_next;

  rule_t             rule_mem [RULE_COUNT];
  logic [RULE_COUNT-1:0] rule_valid;
  rule_t             rd_rule;
  logic              rd_valid;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  wr_addr;
  logic [6:0]        req_idx7;

  assign req_idx7 = {2'b00, req.rule_index};
  assign wr_addr  = req_idx7[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rule_mem[wr_addr] <= rule_t'({req.weekday_mask, req.month_mask, req.day_mask,
                                    req.hour_mask, req.minute_mask});
    end
    rd_rule  <= rule_mem[rd_addr];
    rd_valid <= rule_valid[rd_addr];
  end

  // set-time clamping
  logic [11:0] y_cl;
  logic [3:0]  m_cl;
  logic [4:0]  d_cl, h_cl, len_cl;
  logic [5:0]  mi_cl;

  always_comb begin
    y_cl = req.year;
    if (req.year < YEAR_MIN) y_cl = YEAR_MIN;
    if (req.year > YEAR_MAX) y_cl = YEAR_MAX;
    m_cl = req.month;
    if (req.month == 4'd0) m_cl = 4'd1;
    if (req.month > 4'd12) m_cl = 4'd12;
    len_cl = month_len(m_cl, is_leap(y_cl));
    d_cl = req.day;
    if (req.day == 5'd0) d_cl = 5'd1;
    if (req.day > len_cl) d_cl = len_cl;
    h_cl  = (req.hour > 5'd23) ? 5'd23 : req.hour;
    mi_cl = (req.minute > 6'd59) ? 6'd59 : req.minute;
  end

  // weekday from current date: days since 1970-01-01 plus 3, mod 7, plus 1
  logic [11:0] y_m1, leaps;
  logic [7:0]  yoff, wsum;
  logic [2:0]  wday;
  logic        adj;

  always_comb begin
    yoff  = 8'(cur_year - 12'd1970);
    y_m1  = cur_year - 12'd1;
    leaps = {2'b00, y_m1[11:2]} - 12'd492;
    adj   = is_leap(cur_year) && (cur_month > 4'd2);
    wsum  = yoff + {2'b00, leaps[5:0]} + {5'b0, month_ofs7(cur_month)}
          + {7'b0, adj} + {3'b0, cur_day - 5'd1} + 8'd3;
    wday  = mod7(wsum) + 3'd1;
  end

  logic hit, out_free, stall, at_end;
  logic [6:0] pend7;

  assign hit = rd_valid
             && rd_rule.minute_mask[cur_minute]
             && rd_rule.hour_mask[cur_hour]
             && rd_rule.day_mask[cur_day - 5'd1]
             && rd_rule.month_mask[cur_month - 4'd1]
             && rd_rule.weekday_mask[cur_weekday - 3'd1];
  assign out_free = !out_valid || m_tready;
  assign stall    = hit && pend_valid && !out_free;
  assign at_end   = (cur_year == YEAR_MAX) && (cur_month == 4'd12)
                 && (cur_day == 5'd31) && (cur_hour == 5'd23) && (cur_minute == 6'd59);
  assign pend7    = 7'(pend_rule);

  out_t pend_out;
  always_comb begin
    pend_out.matched_rule  = pend7[4:0];
    pend_out.match_year    = cur_year;
    pend_out.match_month   = cur_month;
    pend_out.match_day     = cur_day;
    pend_out.match_hour    = cur_hour;
    pend_out.match_minute  = cur_minute;
    pend_out.match_weekday = cur_weekday;
  end

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    pend_valid_next  = pend_valid;
    pend_rule_next   = pend_rule;
    out_valid_next   = out_valid && !m_tready;
    out_data_next    = out_data;
    out_last_next    = out_last;
    cur_year_next    = cur_year;
    cur_month_next   = cur_month;
    cur_day_next     = cur_day;
    cur_hour_next    = cur_hour;
    cur_minute_next  = cur_minute;
    cur_weekday_next = cur_weekday;
    rd_addr          = '0;
    mem_we           = 1'b0;
    s_tready         = 1'b0;

    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (op)
            OP_SET: begin
              cur_year_next   = y_cl;
              cur_month_next  = m_cl;
              cur_day_next    = d_cl;
              cur_hour_next   = h_cl;
              cur_minute_next = mi_cl;
              state_next      = ST_WDAY;
            end
            OP_LOAD: begin
              mem_we = (req_idx7 < RULE_LIM);
            end
            OP_TICK: begin
              idx_next        = '0;
              pend_valid_next = 1'b0;
              state_next      = ST_SCAN;
            end
            default: ;
          endcase
        end
      end

      ST_WDAY: begin
        cur_weekday_next = wday;
        state_next       = ST_IDLE;
      end

      ST_SCAN: begin
        if (stall) begin
          rd_addr = idx;
        end else begin
          rd_addr = (idx == IDX_LAST) ? '0 : idx + 1'b1;
          if (hit) begin
            if (pend_valid) begin
              out_valid_next = 1'b1;
              out_data_next  = pend_out;
              out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_rule_next  = idx;
          end
          if (idx == IDX_LAST) begin
            state_next = ST_FLUSH;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_valid || out_free) begin
          if (pend_valid) begin
            out_valid_next = 1'b1;
            out_data_next  = pend_out;
            out_last_next  = 1'b1;
          end
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
          if (!at_end) begin
            if (cur_minute != 6'd59) begin
              cur_minute_next = cur_minute + 6'd1;
            end else begin
              cur_minute_next = 6'd0;
              if (cur_hour != 5'd23) begin
                cur_hour_next = cur_hour + 5'd1;
              end else begin
                cur_hour_next    = 5'd0;
                cur_weekday_next = (cur_weekday == 3'd7) ? 3'd1 : cur_weekday + 3'd1;
                if (cur_day < month_len(cur_month, is_leap(cur_year))) begin
                  cur_day_next = cur_day + 5'd1;
                end else begin
                  cur_day_next = 5'd1;
                  if (cur_month != 4'd12) begin
                    cur_month_next = cur_month + 4'd1;
                  end else begin
                    cur_month_next = 4'd1;
                    cur_year_next  = cur_year + 12'd1;
                  end
                end
              end
            end
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      idx         <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
      rule_valid  <= '0;
      cur_year    <= YEAR_MIN;
      cur_month   <= 4'd1;
      cur_day     <= 5'd1;
      cur_hour    <= 5'd0;
      cur_minute  <= 6'd0;
      cur_weekday <= 3'd4;
    end else begin
      state       <= state_next;
      idx         <= idx_next;
      pend_valid  <= pend_valid_next;
      out_valid   <= out_valid_next;
      if (mem_we) rule_valid[wr_addr] <= 1'b1;
      cur_year    <= cur_year_next;
      cur_month   <= cur_month_next;
      cur_day     <= cur_day_next;
      cur_hour    <= cur_hour_next;
      cur_minute  <= cur_minute_next;
      cur_weekday <= cur_weekday_next;
    end
    pend_rule <= pend_rule_next;
    out_data  <= out_data_next;
    out_last  <= out_last_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;

endmodule

@@ rtl/core/ccm_checker.sv @@
// ----------------------------------------------------------------------------
// ccm_checker
// Port-level assertions for the calendar clock cron matcher.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccm_checker
  import ccm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [1:0]            s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast
);

  `ASSERT_ALWAYS(a_rst_idle, rst |=> !m_tvalid && s_tready, "reset did not idle the block")

  `ASSERT_CHK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

  `ASSERT_CHK(a_tick_busy, s_tvalid && s_tready && (s_tuser == OP_TICK) |=> !s_tready, "tick request did not start a scan")

  `ASSERT_CHK(a_set_busy, s_tvalid && s_tready && (s_tuser == OP_SET) |=> !s_tready, "set request skipped weekday step")

  `ASSERT_CHK(a_out_time, m_tvalid |-> (m_tdata[36:31] < 6'd60) && (m_tdata[30:26] < 5'd24) && (m_tdata[39:37] != 3'd0), "result time out of range")

endmodule

bind calendar_clock_cron_matcher_unit ccm_checker u_ccm_checker (.*);
